FILE: sv/dht_pkg.sv
// Shared types, codes and defaults for the double-hashing table.
`default_nettype none

package dht_pkg;

	localparam int KEY_W            = 31;
	localparam int DEF_TABLE_SIZE   = 11;
	localparam int DEF_STEP_MOD     = 5;
	localparam int DEF_QUEUE_DEPTH  = 2;

	// request codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_FIND   = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	// result codes
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_FOUND     = 3'd1;
	localparam logic [2:0] ST_DELETED   = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef enum logic [1:0] {
		MARK_EMPTY,
		MARK_USED,
		MARK_DELETED
	} mark_t;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] slot;
		logic [3:0] probes;
	} res_t;

endpackage

`default_nettype wire

FILE: sv/dht_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dht_ram #(
	parameter int WIDTH = dht_pkg::KEY_W,
	parameter int DEPTH = dht_pkg::DEF_TABLE_SIZE
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: sv/dht_front.sv
// Front end: takes a request, reduces the key to home slot and probe step.
`default_nettype none

module dht_front #(
	parameter int TABLE_SIZE = dht_pkg::DEF_TABLE_SIZE,
	parameter int STEP_MOD   = dht_pkg::DEF_STEP_MOD
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire dht_pkg::req_t       req,
	output logic                     busy,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [1:0]               out_op,
	output logic [dht_pkg::KEY_W-1:0] out_key,
	output logic [$clog2(TABLE_SIZE)-1:0] out_home,
	output logic [$clog2(TABLE_SIZE)-1:0] out_step
);

	import dht_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_SIZE);
	localparam int TW     = IDX_W + 1;
	localparam int SR_W   = $clog2(STEP_MOD);
	localparam int SW     = SR_W + 1;
	localparam int STEP_W = $clog2(STEP_MOD + 1);
	localparam int CHUNK  = 8;
	localparam int CHUNKS = (KEY_W + CHUNK - 1) / CHUNK;
	localparam int SH_W   = CHUNKS * CHUNK;
	localparam int CNT_W  = $clog2(CHUNKS);

	typedef enum logic [1:0] {
		F_IDLE,
		F_RED,
		F_STEP,
		F_PUSH
	} fstate_t;

	fstate_t           state_q;
	logic [1:0]        op_q;
	logic [KEY_W-1:0]  key_q;
	logic [SH_W-1:0]   sh_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  rt_q;
	logic [SR_W-1:0]   rs_q;
	logic [IDX_W-1:0]  step_q;

	logic [IDX_W-1:0]  rt_nxt;
	logic [SR_W-1:0]   rs_nxt;
	logic [TW-1:0]     tt;
	logic [SW-1:0]     ts;
	logic [CHUNK-1:0]  kb;
	logic [STEP_W-1:0] step_full;
	logic [IDX_W-1:0]  step_red;
	logic [TW-1:0]     tu;

	// eight bits of the key a cycle, both remainders side by side
	always_comb begin
		kb     = sh_q[SH_W-1 -: CHUNK];
		rt_nxt = rt_q;
		rs_nxt = rs_q;
		tt     = '0;
		ts     = '0;
		for (int i = CHUNK - 1; i >= 0; i--) begin
			tt = {rt_nxt, kb[i]};
			if (tt >= TW'(TABLE_SIZE)) begin
				tt = tt - TW'(TABLE_SIZE);
			end
			rt_nxt = tt[IDX_W-1:0];
			ts = {rs_nxt, kb[i]};
			if (ts >= SW'(STEP_MOD)) begin
				ts = ts - SW'(STEP_MOD);
			end
			rs_nxt = ts[SR_W-1:0];
		end
	end

	// step in 1..STEP_MOD, folded below TABLE_SIZE
	always_comb begin
		step_full = STEP_W'(STEP_MOD) - STEP_W'(rs_q);
		step_red  = '0;
		tu        = '0;
		for (int i = STEP_W - 1; i >= 0; i--) begin
			tu = {step_red, step_full[i]};
			if (tu >= TW'(TABLE_SIZE)) begin
				tu = tu - TW'(TABLE_SIZE);
			end
			step_red = tu[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (start) begin
						op_q    <= req.req_type;
						key_q   <= req.key;
						sh_q    <= SH_W'(req.key);
						cnt_q   <= '0;
						rt_q    <= '0;
						rs_q    <= '0;
						state_q <= F_RED;
					end
				end
				F_RED: begin
					rt_q  <= rt_nxt;
					rs_q  <= rs_nxt;
					sh_q  <= sh_q << CHUNK;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(CHUNKS - 1)) begin
						state_q <= F_STEP;
					end
				end
				F_STEP: begin
					step_q  <= step_red;
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (out_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != F_IDLE);
	assign out_valid = (state_q == F_PUSH);
	assign out_op    = op_q;
	assign out_key   = key_q;
	assign out_home  = rt_q;
	assign out_step  = step_q;

endmodule

`default_nettype wire

FILE: sv/dht_queue.sv
// Short FIFO between the key reduction front end and the probe engine.
`default_nettype none

module dht_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = dht_pkg::DEF_QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  wire logic             out_pop,
	output logic      [WIDTH-1:0] out_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = (cnt_q != CW'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;
	assign out_data  = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/dht_back.sv
// Probe engine: walks the double-hash sequence, owns slot marks and key store.
`default_nettype none

module dht_back #(
	parameter int TABLE_SIZE = dht_pkg::DEF_TABLE_SIZE
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_valid,
	output logic                              q_pop,
	input  wire logic [1:0]                   q_op,
	input  wire logic [dht_pkg::KEY_W-1:0]    q_key,
	input  wire logic [$clog2(TABLE_SIZE)-1:0] q_home,
	input  wire logic [$clog2(TABLE_SIZE)-1:0] q_step,
	output logic                              done,
	output dht_pkg::res_t                     result
);

	import dht_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int TW    = IDX_W + 1;
	localparam int CNT_W = $clog2(TABLE_SIZE + 1);

	typedef enum logic {
		B_IDLE,
		B_PROBE
	} bstate_t;

	bstate_t          state_q;
	logic [1:0]       op_q;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] step_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] n_q;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [CNT_W-1:0] n_s1;
	mark_t            marks_q [TABLE_SIZE];
	logic             done_q;
	res_t             result_q;

	logic [KEY_W-1:0] rdata;
	logic             issue;
	logic [TW-1:0]    sum;
	logic [IDX_W-1:0] idx_nxt;
	mark_t            mark_s1;
	logic             hit;
	logic             last;
	logic             fin;
	logic             op_ok;
	res_t             res_nxt;
	logic             wr_key;

	dht_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_SIZE)
	) u_keys (
		.clk  (clk),
		.we   (wr_key),
		.waddr(idx_s1),
		.wdata(key_q),
		.raddr(idx_q),
		.rdata(rdata)
	);

	assign issue   = (state_q == B_PROBE) && (n_q < CNT_W'(TABLE_SIZE));
	assign sum     = TW'(idx_q) + TW'(step_q);
	assign idx_nxt = (sum >= TW'(TABLE_SIZE)) ? IDX_W'(sum - TW'(TABLE_SIZE)) : IDX_W'(sum);
	assign mark_s1 = marks_q[idx_s1];
	assign last    = (n_s1 == CNT_W'(TABLE_SIZE - 1));
	assign op_ok   = q_op inside {OP_INSERT, OP_FIND, OP_DELETE};
	assign q_pop   = (state_q == B_IDLE) && q_valid;

	// decision on the slot whose key has just come out of the store
	always_comb begin
		hit     = 1'b0;
		res_nxt = '{status: ST_NOT_FOUND, slot: 4'd0, probes: 4'(n_s1)};
		if (op_q == OP_INSERT) begin
			if (mark_s1 != MARK_USED) begin
				hit     = 1'b1;
				res_nxt = '{status: ST_INSERTED, slot: 4'(idx_s1), probes: 4'(n_s1)};
			end
		end else begin
			if (mark_s1 == MARK_EMPTY) begin
				hit = 1'b1;
			end else if (mark_s1 == MARK_USED && rdata == key_q) begin
				hit     = 1'b1;
				res_nxt = '{status: (op_q == OP_DELETE) ? ST_DELETED : ST_FOUND,
					slot: 4'(idx_s1), probes: 4'(n_s1)};
			end
		end
		if (!hit) begin
			res_nxt = '{status: (op_q == OP_INSERT) ? ST_FULL : ST_NOT_FOUND,
				slot: 4'd0, probes: 4'(TABLE_SIZE)};
		end
	end

	assign fin    = valid_s1 && (hit || last);
	assign wr_key = fin && hit && (op_q == OP_INSERT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SIZE; i++) begin
				marks_q[i] <= MARK_EMPTY;
			end
		end else if (fin && hit) begin
			if (op_q == OP_INSERT) begin
				marks_q[idx_s1] <= MARK_USED;
			end else if (op_q == OP_DELETE && mark_s1 == MARK_USED) begin
				marks_q[idx_s1] <= MARK_DELETED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
			n_q      <= '0;
		end else begin
			done_q   <= 1'b0;
			valid_s1 <= issue && !fin;
			idx_s1   <= idx_q;
			n_s1     <= n_q;
			case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						op_q   <= q_op;
						key_q  <= q_key;
						step_q <= q_step;
						idx_q  <= q_home;
						n_q    <= '0;
						if (op_ok) begin
							state_q <= B_PROBE;
						end else begin
							done_q   <= 1'b1;
							result_q <= '{status: ST_NOT_FOUND, slot: 4'd0, probes: 4'd0};
						end
					end
				end
				B_PROBE: begin
					if (issue) begin
						idx_q <= idx_nxt;
						n_q   <= n_q + 1'b1;
					end
					if (fin) begin
						done_q   <= 1'b1;
						result_q <= res_nxt;
						state_q  <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

FILE: sv/double_hash_table.sv
// Double-hashing table (open addressing): key reduction front, queue, probe engine.
// The front end reduces the key and hands it to the queue; the probe engine then walks n
//   probe steps (at most TABLE_SIZE-1) before it reports the result.
// The probe engine works on one request at a time and pops the next only once idle;
//   the front end takes a new request only once idle, and waits while the queue is full.
// Reset: slot marks all go empty at once, key store untouched; done strobes cannot be stalled.
`default_nettype none

module double_hash_table #(
	parameter int TABLE_SIZE  = dht_pkg::DEF_TABLE_SIZE,
	parameter int STEP_MOD    = dht_pkg::DEF_STEP_MOD,
	parameter int QUEUE_DEPTH = dht_pkg::DEF_QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire dht_pkg::req_t req,
	output logic               busy,
	output logic               done,
	output dht_pkg::res_t      result
);

	import dht_pkg::*;

	localparam int IDX_W = $clog2(TABLE_SIZE);
	// queue beat: request code, key, home slot, reduced step
	localparam int E_W   = 2 + KEY_W + 2 * IDX_W;

	logic             f_valid;
	logic             f_ready;
	logic [1:0]       f_op;
	logic [KEY_W-1:0] f_key;
	logic [IDX_W-1:0] f_home;
	logic [IDX_W-1:0] f_step;

	logic             q_valid;
	logic             q_pop;
	logic [E_W-1:0]   q_data;
	logic [1:0]       q_op;
	logic [KEY_W-1:0] q_key;
	logic [IDX_W-1:0] q_home;
	logic [IDX_W-1:0] q_step;

	// Front end: busy while it reduces a key or waits for queue space.
	dht_front #(
		.TABLE_SIZE(TABLE_SIZE),
		.STEP_MOD  (STEP_MOD)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.busy     (busy),
		.out_valid(f_valid),
		.out_ready(f_ready),
		.out_op   (f_op),
		.out_key  (f_key),
		.out_home (f_home),
		.out_step (f_step)
	);

	// Queue lets the front end run ahead while a long probe walk is in progress.
	dht_queue #(
		.WIDTH(E_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (f_valid),
		.in_ready (f_ready),
		.in_data  ({f_op, f_key, f_home, f_step}),
		.out_valid(q_valid),
		.out_pop  (q_pop),
		.out_data (q_data)
	);

	assign {q_op, q_key, q_home, q_step} = q_data;

	// Probe engine: one slot a cycle, each slot's key read from the store and checked in the cycle after it is issued.
	dht_back #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_pop (q_pop),
		.q_op  (q_op),
		.q_key (q_key),
		.q_home(q_home),
		.q_step(q_step),
		.done  (done),
		.result(result)
	);

	// A full-table result reports every slot probed.
	a_full_probes: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == ST_FULL |-> result.probes == 4'(TABLE_SIZE))
		else $error("full table result without a full probe count");

	// Misses carry slot zero.
	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_NOT_FOUND || result.status == ST_FULL)
		|-> result.slot == 4'd0)
		else $error("miss result with nonzero slot");

	// Probe count never exceeds the table size.
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.probes <= 4'(TABLE_SIZE))
		else $error("probe count beyond table size");

	// A beat offered by the front end stays until the queue takes it.
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid && !f_ready |=> f_valid && $stable(f_key) && $stable(f_home))
		else $error("front end dropped a beat before the queue took it");

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the double-hashing table: directed corner cases, then random traffic.
`default_nettype none

module testbench;

	import dht_pkg::*;

	// Geometry matches the block's defaults; the table is never re-parameterised here.
	localparam int TABLE_SLOTS  = DEF_TABLE_SIZE;
	localparam int STRIDE_MOD   = DEF_STEP_MOD;

	// The request field is two bits wide; the fourth code is not an operation.
	localparam logic [1:0] OP_ILLEGAL = 2'd3;

	localparam logic [KEY_W-1:0] KEY_MAX = '1;

	localparam int RANDOM_BEATS = 880;
	localparam int KEY_POOL     = 16;
	// Tail after the last expected result: key reduction plus a worst-case probe run.
	localparam int DRAIN_CYCLES = 40;
	// Covers the worst beat in the block plus the longest gap; ~900 beats, many times over.
	localparam int unsigned CYCLE_LIMIT = 400000;

	logic  clk    = 1'b0;
	logic  arst_n = 1'b0;
	logic  start  = 1'b0;
	req_t  req    = '0;
	logic  busy;
	logic  done;
	res_t  result;

	// Shadow copy of the table, updated as each request beat is accepted.
	logic [KEY_W-1:0] shadow_keys [TABLE_SLOTS];
	mark_t            shadow_marks [TABLE_SLOTS] = '{default: MARK_EMPTY};

	res_t        expected_results [$];
	res_t        oldest_result;
	int          errors          = 0;
	int          requests_sent   = 0;
	int          results_checked = 0;
	int          op_count [4]    = '{default: 0};
	int          status_count [8] = '{default: 0};
	int unsigned cycle_count     = 0;
	bit          no_gaps         = 1'b0;

	logic [KEY_W-1:0] key_pool [KEY_POOL];

	double_hash_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always #1 clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends up here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Predicts one request against the shadow table and applies its side effects.
	// Home slot is key mod size; stride is STRIDE_MOD - key mod STRIDE_MOD, so never zero.
	function automatic res_t predict_table_op(input req_t r);
		res_t        res;
		int unsigned pos;
		int unsigned stride;
		pos    = r.key % TABLE_SLOTS;
		stride = STRIDE_MOD - (r.key % STRIDE_MOD);
		res.status = ST_NOT_FOUND;
		res.slot   = '0;
		res.probes = '0;
		if (r.req_type == OP_ILLEGAL)
			return res;
		for (int n = 0; n < TABLE_SLOTS; n++) begin
			if (r.req_type == OP_INSERT) begin
				// first free or tombstoned slot wins; duplicates are not detected
				if (shadow_marks[pos] != MARK_USED) begin
					shadow_keys[pos]  = r.key;
					shadow_marks[pos] = MARK_USED;
					res.status = ST_INSERTED;
					res.slot   = pos[3:0];
					res.probes = n[3:0];
					return res;
				end
			end else begin
				// an empty slot ends the search; tombstones are stepped over
				if (shadow_marks[pos] == MARK_EMPTY) begin
					res.probes = n[3:0];
					return res;
				end
				if (shadow_marks[pos] == MARK_USED && shadow_keys[pos] == r.key) begin
					if (r.req_type == OP_DELETE) begin
						shadow_marks[pos] = MARK_DELETED;
						res.status = ST_DELETED;
					end else begin
						res.status = ST_FOUND;
					end
					res.slot   = pos[3:0];
					res.probes = n[3:0];
					return res;
				end
			end
			pos = (pos + stride) % TABLE_SLOTS;
		end
		// whole probe sequence walked without a hit or a free slot
		res.status = (r.req_type == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
		res.probes = 4'(TABLE_SLOTS);
		return res;
	endfunction

	// Gap after a beat: mostly none or short, now and then long; none at all in a burst.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_gaps || roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Sends a request beat; called right after the clock rises, it returns after acceptance and any gap.
	// With no gap, start stays high and the next call simply updates req.
	task automatic send_request(input logic [1:0] op, input logic [KEY_W-1:0] k);
		req_t r;
		res_t res;
		int   gap;
		r.req_type = op;
		r.key      = k;
		req   <= r;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		res = predict_table_op(r);
		expected_results.push_back(res);
		requests_sent++;
		op_count[op]++;
		status_count[res.status]++;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Results cannot be stalled: every done strobe is taken at the edge closing its cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: status %0d slot %0d probes %0d",
					result.status, result.slot, result.probes);
				errors++;
			end else begin
				oldest_result = expected_results.pop_front();
				results_checked++;
				if (result.status !== oldest_result.status) begin
					$error("status: expected %0d, got %0d", oldest_result.status, result.status);
					errors++;
				end
				if (result.slot !== oldest_result.slot) begin
					$error("slot: expected %0d, got %0d", oldest_result.slot, result.slot);
					errors++;
				end
				if (result.probes !== oldest_result.probes) begin
					$error("probes: expected %0d, got %0d", oldest_result.probes, result.probes);
					errors++;
				end
			end
		end
	end

	// Fresh table: lookups hit an empty home slot straight away.
	task automatic test_empty_lookups();
		send_request(OP_FIND, '0);
		send_request(OP_DELETE, KEY_MAX);
	endtask

	// The spare request code must leave the table alone and report not found.
	task automatic test_illegal_request();
		send_request(OP_ILLEGAL, 31'd5);
		send_request(OP_ILLEGAL, KEY_MAX);
	endtask

	// Keys sharing home slot 0 with different strides, a duplicate and the largest key.
	task automatic test_collisions();
		send_request(OP_INSERT, 31'd0);
		send_request(OP_INSERT, 31'd11);
		send_request(OP_INSERT, 31'd22);
		send_request(OP_INSERT, 31'd0);
		send_request(OP_INSERT, KEY_MAX);
	endtask

	// Deletes leave tombstones: searches step over them, inserts reclaim them.
	task automatic test_tombstones();
		send_request(OP_FIND, 31'd11);
		send_request(OP_DELETE, 31'd0);
		send_request(OP_FIND, 31'd0);
		send_request(OP_FIND, 31'd33);
		send_request(OP_DELETE, 31'd33);
		send_request(OP_INSERT, 31'd33);
		send_request(OP_FIND, 31'd22);
	endtask

	// Fill every slot, then one more insert must report the table full.
	task automatic test_table_full();
		int used;
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			used = 0;
			foreach (shadow_marks[s])
				if (shadow_marks[s] == MARK_USED)
					used++;
			if (used == TABLE_SLOTS)
				break;
			send_request(OP_INSERT, 31'(100 + 13 * i));
		end
		send_request(OP_INSERT, 31'd7);
	endtask

	// No empty slot left: searches for absent keys run the full probe sequence.
	task automatic test_exhausted_search();
		send_request(OP_FIND, 31'd7);
		send_request(OP_DELETE, 31'd12345);
	endtask

	// Mostly pool keys so finds and deletes hit; some fresh wide keys for bit coverage.
	task automatic test_random_traffic();
		int               roll;
		logic [1:0]       op;
		logic [KEY_W-1:0] k;
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = (i < KEY_POOL / 2) ? 31'(i * TABLE_SLOTS + $urandom_range(0, 1))
				: 31'($urandom());
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 40 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 19) == 0)
				key_pool[$urandom_range(0, KEY_POOL - 1)] = 31'($urandom());
			roll = $urandom_range(0, 99);
			if (roll < 36)
				op = OP_INSERT;
			else if (roll < 66)
				op = OP_FIND;
			else if (roll < 96)
				op = OP_DELETE;
			else
				op = OP_ILLEGAL;
			if ($urandom_range(0, 9) == 0)
				k = 31'($urandom());
			else
				k = key_pool[$urandom_range(0, KEY_POOL - 1)];
			send_request(op, k);
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_lookups();
		test_illegal_request();
		test_collisions();
		test_tombstones();
		test_table_full();
		test_exhausted_search();
		test_random_traffic();
		start <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d request beats (insert %0d, find %0d, delete %0d, illegal %0d), %0d results checked",
			requests_sent, op_count[OP_INSERT], op_count[OP_FIND], op_count[OP_DELETE],
			op_count[OP_ILLEGAL], results_checked);
		$display("outcomes: inserted %0d, found %0d, deleted %0d, not found %0d, full %0d",
			status_count[ST_INSERTED], status_count[ST_FOUND], status_count[ST_DELETED],
			status_count[ST_NOT_FOUND], status_count[ST_FULL]);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
